// File: hw/rtl/lcd4seq_pkg.sv
// Shared job descriptor types for the LCD 4-bit bus sequencer.
`default_nettype none

package lcd4seq_pkg;

    // Kinds of bus work that the front hands to the back
    typedef enum logic [1:0] {
        JOB_INIT  = 2'd0,  // power-on nibble sequence followed by a status read
        JOB_READ  = 2'd1,  // single status nibble read
        JOB_WRITE = 2'd2   // byte as two nibbles, optionally followed by a status read
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  byte_value;
        logic        reg_select;
        logic        chain;       // write job: a further byte follows, so poll again
    } t_job;

    // Op index of the final bus operation of each job kind
    localparam logic [2:0] INIT_LAST_IDX  = 3'd7;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd1;
    localparam logic [2:0] CHAIN_LAST_IDX = 3'd2;
    localparam logic [2:0] READ_LAST_IDX  = 3'd0;

endpackage

`default_nettype wire

// File: hw/rtl/lcd4seq_front.sv
// Request front end: tracks the busy poll and turns requests into bus jobs.
`default_nettype none

module lcd4seq_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [2:0]         i_cmd,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic [5:0]         i_cursor_column,
    input  wire logic               i_cursor_row,
    input  wire logic [3:0]         i_status_nibble,
    input  wire logic               i_q_full,
    output logic                    o_stall,
    output logic                    o_push,
    output lcd4seq_pkg::t_job       o_job
);

    localparam logic [2:0] CMD_INIT     = 3'd0;
    localparam logic [2:0] CMD_WR_CMD   = 3'd1;
    localparam logic [2:0] CMD_WR_DATA  = 3'd2;
    localparam logic [2:0] CMD_CURSOR   = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;
    localparam logic [2:0] CMD_STATUS   = 3'd5;

    localparam logic [2:0] STEP_NONE    = 3'd0;
    localparam logic [2:0] STEP_FUNC    = 3'd1;
    localparam logic [2:0] STEP_CLEAR   = 3'd5;

    localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [7:0] BYTE_DDRAM    = 8'h80;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_WAIT_LOW  = 2'd2
    } t_phase;

    // Byte sent at each position of a multi-byte sequence
    function automatic logic [7:0] seq_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h80;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Position that follows; zero ends the sequence
    function automatic logic [2:0] seq_next(input logic [2:0] step);
        logic [2:0] s;
        case (step)
            3'd1:    s = 3'd2;
            3'd2:    s = 3'd3;
            3'd3:    s = 3'd4;
            3'd5:    s = 3'd6;
            default: s = STEP_NONE;
        endcase
        return s;
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pending_byte, n_pending_byte;
    logic        r_pending_select, n_pending_select;
    logic        r_busy_seen, n_busy_seen;
    logic [2:0]  r_step, n_step;
    logic        accept;
    logic [2:0]  nx;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_phase          = r_phase;
        n_pending_byte   = r_pending_byte;
        n_pending_select = r_pending_select;
        n_busy_seen      = r_busy_seen;
        n_step           = r_step;
        nx               = seq_next(r_step);
        o_push           = 1'b0;
        o_job.kind       = lcd4seq_pkg::JOB_READ;
        o_job.byte_value = r_pending_byte;
        o_job.reg_select = r_pending_select;
        o_job.chain      = 1'b0;

        if (accept) begin
            if (i_cmd == CMD_STATUS) begin
                case (r_phase)
                    PH_WAIT_HIGH: begin
                        // keep the busy flag, read the low nibble next
                        n_busy_seen = i_status_nibble[3];
                        n_phase     = PH_WAIT_LOW;
                        o_push      = 1'b1;
                    end
                    PH_WAIT_LOW: begin
                        o_push = 1'b1;
                        if (r_busy_seen) begin
                            n_busy_seen = 1'b0;
                            n_phase     = PH_WAIT_HIGH;
                        end else begin
                            o_job.kind  = lcd4seq_pkg::JOB_WRITE;
                            o_job.chain = (nx != STEP_NONE);
                            n_busy_seen = 1'b0;
                            if (nx != STEP_NONE) begin
                                n_pending_byte   = seq_byte(nx);
                                n_pending_select = 1'b0;
                                n_step           = nx;
                                n_phase          = PH_WAIT_HIGH;
                            end else begin
                                n_step  = STEP_NONE;
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        // drop stray answers while idle
                    end
                endcase
            end else if (r_phase == PH_IDLE && i_cmd <= CMD_CLEAR) begin
                o_push           = 1'b1;
                n_busy_seen      = 1'b0;
                n_phase          = PH_WAIT_HIGH;
                n_pending_select = 1'b0;
                n_step           = STEP_NONE;
                case (i_cmd)
                    CMD_INIT: begin
                        o_job.kind     = lcd4seq_pkg::JOB_INIT;
                        n_pending_byte = BYTE_FUNC_SET;
                        n_step         = STEP_FUNC;
                    end
                    CMD_WR_CMD: begin
                        n_pending_byte = i_byte_value;
                    end
                    CMD_WR_DATA: begin
                        n_pending_byte   = i_byte_value;
                        n_pending_select = 1'b1;
                    end
                    CMD_CURSOR: begin
                        n_pending_byte = BYTE_DDRAM | {1'b0, i_cursor_row, i_cursor_column};
                    end
                    default: begin
                        n_pending_byte = BYTE_CLEAR;
                        n_step         = STEP_CLEAR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_pending_byte   <= 8'h00;
            r_pending_select <= 1'b0;
            r_busy_seen      <= 1'b0;
            r_step           <= STEP_NONE;
        end else begin
            r_phase          <= n_phase;
            r_pending_byte   <= n_pending_byte;
            r_pending_select <= n_pending_select;
            r_busy_seen      <= n_busy_seen;
            r_step           <= n_step;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd4seq_queue.sv
// Small job queue between the front end and the bus driver.
`default_nettype none

module lcd4seq_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire lcd4seq_pkg::t_job  i_job,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output lcd4seq_pkg::t_job       o_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcd4seq_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd4seq_back.sv
// Bus driver: expands each queued job into its bus operations.
`default_nettype none

module lcd4seq_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire lcd4seq_pkg::t_job  i_q_job,
    input  wire logic               i_stall,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic [1:0]              o_bus_op,
    output logic                    o_reg_select,
    output logic [3:0]              o_nibble_out,
    output logic [6:0]              o_pause_units,
    output logic                    o_last
);

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_PAUSE    = 2'd2;

    localparam logic [6:0] PAUSE_LONG  = 7'd100;
    localparam logic [6:0] PAUSE_SHORT = 7'd10;
    localparam logic [3:0] NIB_WAKE    = 4'h3;
    localparam logic [3:0] NIB_4BIT    = 4'h2;

    logic              r_busy;
    logic [2:0]        r_idx;
    lcd4seq_pkg::t_job r_job;
    logic [2:0]        last_idx;
    logic              out_accept;
    logic              load;

    always_comb begin
        case (r_job.kind)
            lcd4seq_pkg::JOB_INIT:  last_idx = lcd4seq_pkg::INIT_LAST_IDX;
            lcd4seq_pkg::JOB_WRITE: last_idx = r_job.chain ? lcd4seq_pkg::CHAIN_LAST_IDX
                                                           : lcd4seq_pkg::WRITE_LAST_IDX;
            default:                last_idx = lcd4seq_pkg::READ_LAST_IDX;
        endcase
    end

    assign o_valid    = r_busy;
    assign o_last     = (r_idx == last_idx);
    assign out_accept = r_busy && !i_stall;
    assign load       = i_q_valid && (!r_busy || (out_accept && o_last));
    assign o_pop      = load;

    // Decode the current op; reads and pauses carry zero select and nibble
    always_comb begin
        o_bus_op      = OP_READ;
        o_reg_select  = 1'b0;
        o_nibble_out  = 4'h0;
        o_pause_units = 7'd0;
        case (r_job.kind)
            lcd4seq_pkg::JOB_INIT: begin
                case (r_idx)
                    3'd0, 3'd2: begin
                        o_bus_op      = OP_PAUSE;
                        o_pause_units = PAUSE_LONG;
                    end
                    3'd4: begin
                        o_bus_op      = OP_PAUSE;
                        o_pause_units = PAUSE_SHORT;
                    end
                    3'd1, 3'd3, 3'd5: begin
                        o_bus_op     = OP_WRITE;
                        o_nibble_out = NIB_WAKE;
                    end
                    3'd6: begin
                        o_bus_op     = OP_WRITE;
                        o_nibble_out = NIB_4BIT;
                    end
                    default: begin
                        o_bus_op = OP_READ;
                    end
                endcase
            end
            lcd4seq_pkg::JOB_WRITE: begin
                case (r_idx)
                    3'd0: begin
                        o_bus_op     = OP_WRITE;
                        o_reg_select = r_job.reg_select;
                        o_nibble_out = r_job.byte_value[7:4];
                    end
                    3'd1: begin
                        o_bus_op     = OP_WRITE;
                        o_reg_select = r_job.reg_select;
                        o_nibble_out = r_job.byte_value[3:0];
                    end
                    default: begin
                        o_bus_op = OP_READ;
                    end
                endcase
            end
            default: begin
                o_bus_op = OP_READ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (out_accept) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

    a_init_ends_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.kind == lcd4seq_pkg::JOB_INIT
            && r_idx == lcd4seq_pkg::INIT_LAST_IDX)
        |-> (o_bus_op == OP_READ && o_last))
        else $error("init job does not end in a final status read");

    a_pause_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_op == OP_PAUSE) |-> (o_pause_units != 7'd0))
        else $error("pause issued with zero length");

    a_job_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("job dropped before its final operation");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last && !i_q_valid) |=> !o_valid)
        else $error("operation issued with no job pending");

endmodule

`default_nettype wire

// File: hw/rtl/char_lcd_4bit_bus_sequencer.sv
// Top level of the 4-bit character LCD bus sequencer.
`default_nettype none

// Drives the 4-bit bus of an HD44780-style character display as a stream of
// bus operations: nibble writes with an enable strobe, status nibble reads and
// timed pauses. Host requests (init, write command, write data, set cursor,
// clear) and status answers from the display arrive on one input channel;
// every bus operation leaves on the output channel, and the final operation
// caused by an input request is flagged with o_last. Before each byte the
// busy flag is polled: the block issues a status read, expects the high and
// low status nibbles back as status answers, and repeats the poll while bit 7
// of the status byte is set; then it writes the byte high nibble first with
// the register select bit. Init emits the power-on nibble sequence and then
// the function set, display on, entry mode and home-address commands, each
// behind its own poll; clear sends command 0x01 followed by address 0,0.
// Requests that arrive while a poll is open, status answers while idle and
// undefined command codes are accepted and dropped without any output.
// Throughput: the front end takes one request every cycle as long as the job
// queue (QUEUE_DEPTH entries) has room; the bus driver issues one operation
// per cycle while the output is not stalled. A request makes one operation
// for a poll step, two or three for a byte write and eight for init. A finished
// job hands over to the next queued job in the same cycle, so the output
// runs without gaps while the queue holds work.

module char_lcd_4bit_bus_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [5:0]  i_cursor_column,
    input  wire logic        i_cursor_row,
    input  wire logic [3:0]  i_status_nibble,
    // bus operation channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_bus_op,
    output logic             o_reg_select,
    output logic [3:0]       o_nibble_out,
    output logic [6:0]       o_pause_units,
    output logic             o_last
);

    logic              push, pop, q_full, q_valid;
    lcd4seq_pkg::t_job push_job, head_job;

    // Front end: classify each request, advance the poll state, emit a job
    lcd4seq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_cmd           (i_cmd),
        .i_byte_value    (i_byte_value),
        .i_cursor_column (i_cursor_column),
        .i_cursor_row    (i_cursor_row),
        .i_status_nibble (i_status_nibble),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_job           (push_job)
    );

    // Decouple request intake from a stalled bus
    lcd4seq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Bus driver: walk each job one operation per accepted output
    lcd4seq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (head_job),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_bus_op      (o_bus_op),
        .o_reg_select  (o_reg_select),
        .o_nibble_out  (o_nibble_out),
        .o_pause_units (o_pause_units),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// File: test/tb_char_lcd_4bit_bus_sequencer.sv
// Self-checking testbench for the 4-bit character LCD bus sequencer.
`timescale 1ns / 100ps

module tb_char_lcd_4bit_bus_sequencer;

    // Request codes on i_cmd
    typedef enum logic [2:0] {
        REQ_INIT       = 3'd0,
        REQ_WRITE_CMD  = 3'd1,
        REQ_WRITE_DATA = 3'd2,
        REQ_SET_CURSOR = 3'd3,
        REQ_CLEAR      = 3'd4,
        REQ_STATUS     = 3'd5,
        REQ_UNDEF_6    = 3'd6,
        REQ_UNDEF_7    = 3'd7
    } t_req_cmd;

    // Bus operation codes on o_bus_op
    typedef enum logic [1:0] {
        BUS_WRITE = 2'd0,
        BUS_READ  = 2'd1,
        BUS_PAUSE = 2'd2
    } t_bus_kind;

    typedef enum logic [1:0] {
        POLL_IDLE      = 2'd0,
        POLL_WAIT_HIGH = 2'd1,
        POLL_WAIT_LOW  = 2'd2
    } t_poll_phase;

    // Position inside a multi-byte command sequence
    typedef enum logic [2:0] {
        SEQ_NONE       = 3'd0,
        SEQ_FUNC_SET   = 3'd1,
        SEQ_DISPLAY_ON = 3'd2,
        SEQ_ENTRY_MODE = 3'd3,
        SEQ_HOME_INIT  = 3'd4,
        SEQ_CLEAR      = 3'd5,
        SEQ_HOME_CLEAR = 3'd6
    } t_seq_step;

    typedef struct packed {
        logic [1:0] op;
        logic       rs;
        logic [3:0] nibble;
        logic [6:0] units;
        logic       last;
    } t_bus_op;

    localparam logic [7:0] CMD_FUNC_SET      = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
    localparam logic [7:0] CMD_SET_ADDR      = 8'h80;
    localparam logic [7:0] CMD_CLEAR         = 8'h01;
    localparam logic [7:0] CURSOR_ROW_STRIDE = 8'h40;
    localparam logic [3:0] NIB_WAKE          = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT      = 4'h2;
    localparam logic [6:0] PAUSE_LONG        = 7'd100;
    localparam logic [6:0] PAUSE_SHORT       = 7'd10;

    localparam int          TOTAL_ITEMS      = 380;
    localparam int          HOLD_OFF_AT      = 120;
    localparam int          MAX_GAP          = 17;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          DRAIN_CYCLES     = 32;
    localparam int unsigned CYCLE_LIMIT      = 800_000;
    localparam int          MAX_REPORTS      = 50;

    // Expected bus traffic: predicts the display-side operations for every
    // accepted request and matches them against what leaves the block.
    class lcd_bus_scoreboard;
        t_bus_op     expected[$];
        t_poll_phase phase;
        logic [7:0]  pending_byte;
        logic        pending_select;
        logic        busy_seen;
        t_seq_step   step;
        int          errors;
        int          results_seen;

        function new();
            phase          = POLL_IDLE;
            pending_byte   = 8'h00;
            pending_select = 1'b0;
            busy_seen      = 1'b0;
            step           = SEQ_NONE;
            errors         = 0;
            results_seen   = 0;
        endfunction

        function void push_op(t_bus_kind op, logic rs, logic [3:0] nib, logic [6:0] units);
            t_bus_op item;
            item.op     = op;
            item.rs     = rs;
            item.nibble = nib;
            item.units  = units;
            item.last   = 1'b0;
            expected.push_back(item);
        endfunction

        function logic [7:0] step_byte(t_seq_step s);
            case (s)
                SEQ_FUNC_SET:   return CMD_FUNC_SET;
                SEQ_DISPLAY_ON: return CMD_DISPLAY_ON;
                SEQ_ENTRY_MODE: return CMD_ENTRY_MODE;
                SEQ_CLEAR:      return CMD_CLEAR;
                default:        return CMD_SET_ADDR;
            endcase
        endfunction

        function t_seq_step step_after(t_seq_step s);
            case (s)
                SEQ_FUNC_SET:   return SEQ_DISPLAY_ON;
                SEQ_DISPLAY_ON: return SEQ_ENTRY_MODE;
                SEQ_ENTRY_MODE: return SEQ_HOME_INIT;
                SEQ_CLEAR:      return SEQ_HOME_CLEAR;
                default:        return SEQ_NONE;
            endcase
        endfunction

        // Open a busy poll for the next byte: first status read goes out now
        function void begin_byte(logic [7:0] b, logic rs, t_seq_step s);
            pending_byte   = b;
            pending_select = rs;
            step           = s;
            busy_seen      = 1'b0;
            phase          = POLL_WAIT_HIGH;
            push_op(BUS_READ, 1'b0, 4'h0, 7'd0);
        endfunction

        function void take_status(logic [3:0] nib);
            t_seq_step nx;
            case (phase)
                POLL_WAIT_HIGH: begin
                    busy_seen = nib[3];
                    phase     = POLL_WAIT_LOW;
                    push_op(BUS_READ, 1'b0, 4'h0, 7'd0);
                end
                POLL_WAIT_LOW: begin
                    if (busy_seen) begin
                        // display still busy: poll again from the high nibble
                        busy_seen = 1'b0;
                        phase     = POLL_WAIT_HIGH;
                        push_op(BUS_READ, 1'b0, 4'h0, 7'd0);
                    end else begin
                        push_op(BUS_WRITE, pending_select, pending_byte[7:4], 7'd0);
                        push_op(BUS_WRITE, pending_select, pending_byte[3:0], 7'd0);
                        nx = step_after(step);
                        if (nx != SEQ_NONE) begin
                            begin_byte(step_byte(nx), 1'b0, nx);
                        end else begin
                            phase     = POLL_IDLE;
                            step      = SEQ_NONE;
                            busy_seen = 1'b0;
                        end
                    end
                end
                default: ;  // stray answer while idle: drop it
            endcase
        endfunction

        // Note one accepted request; return how many bus ops it causes
        function int note_request(t_req_cmd cmd, logic [7:0] b, logic [5:0] col,
                                  logic row, logic [3:0] nib);
            int      before_count;
            t_bus_op tail;
            before_count = expected.size();
            if (cmd == REQ_STATUS) begin
                take_status(nib);
            end else if (cmd <= REQ_CLEAR && phase == POLL_IDLE) begin
                case (cmd)
                    REQ_INIT: begin
                        push_op(BUS_PAUSE, 1'b0, 4'h0, PAUSE_LONG);
                        push_op(BUS_WRITE, 1'b0, NIB_WAKE, 7'd0);
                        push_op(BUS_PAUSE, 1'b0, 4'h0, PAUSE_LONG);
                        push_op(BUS_WRITE, 1'b0, NIB_WAKE, 7'd0);
                        push_op(BUS_PAUSE, 1'b0, 4'h0, PAUSE_SHORT);
                        push_op(BUS_WRITE, 1'b0, NIB_WAKE, 7'd0);
                        push_op(BUS_WRITE, 1'b0, NIB_FOUR_BIT, 7'd0);
                        begin_byte(step_byte(SEQ_FUNC_SET), 1'b0, SEQ_FUNC_SET);
                    end
                    REQ_WRITE_CMD:  begin_byte(b, 1'b0, SEQ_NONE);
                    REQ_WRITE_DATA: begin_byte(b, 1'b1, SEQ_NONE);
                    REQ_SET_CURSOR: begin
                        begin_byte((8'(row) * CURSOR_ROW_STRIDE + 8'(col)) | CMD_SET_ADDR,
                                   1'b0, SEQ_NONE);
                    end
                    default:        begin_byte(step_byte(SEQ_CLEAR), 1'b0, SEQ_CLEAR);
                endcase
            end
            // requests during a poll and undefined codes fall through with nothing
            if (expected.size() > before_count) begin
                tail      = expected.pop_back();
                tail.last = 1'b1;
                expected.push_back(tail);
            end
            return expected.size() - before_count;
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] bus op %0d %s: got %0d, want %0d",
                         $time, results_seen, what, got, want);
        endtask

        task check_op(t_bus_op got);
            t_bus_op want;
            results_seen++;
            if (expected.size() == 0) begin
                report("arrived with nothing pending, op", got.op, 0);
            end else begin
                want = expected.pop_front();
                if (got.op != want.op)         report("bus_op", got.op, want.op);
                if (got.rs != want.rs)         report("reg_select", got.rs, want.rs);
                if (got.nibble != want.nibble) report("nibble_out", got.nibble, want.nibble);
                if (got.units != want.units)   report("pause_units", got.units, want.units);
                if (got.last != want.last)     report("last", got.last, want.last);
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_cmd;
    logic [7:0] i_byte_value;
    logic [5:0] i_cursor_column;
    logic       i_cursor_row;
    logic [3:0] i_status_nibble;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_bus_op;
    logic       o_reg_select;
    logic [3:0] o_nibble_out;
    logic [6:0] o_pause_units;
    logic       o_last;

    lcd_bus_scoreboard sb;

    int          sent_count       = 0;
    bit          tx_steady        = 1'b0;
    bit          rx_steady        = 1'b0;
    bit          hold_off_go      = 1'b0;
    bit          rx_freeze        = 1'b0;
    int unsigned cycle_count      = 0;

    char_lcd_4bit_bus_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_byte_value    (i_byte_value),
        .i_cursor_column (i_cursor_column),
        .i_cursor_row    (i_cursor_row),
        .i_status_nibble (i_status_nibble),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bus_op        (o_bus_op),
        .o_reg_select    (o_reg_select),
        .o_nibble_out    (o_nibble_out),
        .o_pause_units   (o_pause_units),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request, hold it until the block takes it, then note it.
    // The gap before it is drawn per request; a frozen receiver or a steady
    // stretch drops the gap so the job queue fills up.
    task automatic send_item(t_req_cmd cmd, logic [7:0] b, logic [5:0] col,
                             logic row, logic [3:0] nib);
        int gap;
        gap = (tx_steady || rx_freeze) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_byte_value    <= b;
        i_cursor_column <= col;
        i_cursor_row    <= row;
        i_status_nibble <= nib;
        do @(posedge i_clk); while (o_stall);
        void'(sb.note_request(cmd, b, col, row, nib));
        sent_count++;
        if (sent_count % 25 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Status answer with random payload in the unused fields
    task automatic send_status(logic [3:0] nib);
        send_item(REQ_STATUS, 8'($urandom), 6'($urandom), 1'($urandom), nib);
    endtask

    // Draw the next request from the predicted poll state: mostly well-formed
    // traffic (requests when idle, status answers while polling), with noise.
    task automatic send_random();
        int         pick;
        t_req_cmd   cmd;
        logic [3:0] nib;
        pick = $urandom_range(0, 99);
        nib  = 4'($urandom);
        if (sb.phase == POLL_IDLE) begin
            if (pick < 4)       cmd = REQ_INIT;
            else if (pick < 28) cmd = REQ_WRITE_CMD;
            else if (pick < 58) cmd = REQ_WRITE_DATA;
            else if (pick < 78) cmd = REQ_SET_CURSOR;
            else if (pick < 88) cmd = REQ_CLEAR;
            else if (pick < 94) cmd = REQ_STATUS;
            else                cmd = ($urandom_range(0, 1) != 0) ? REQ_UNDEF_6 : REQ_UNDEF_7;
        end else begin
            if (pick < 85) begin
                cmd = REQ_STATUS;
                // busy in about a quarter of high answers
                if (sb.phase == POLL_WAIT_HIGH) nib[3] = ($urandom_range(0, 3) == 0);
            end else if (pick < 95) begin
                cmd = t_req_cmd'($urandom_range(0, 4));
            end else begin
                cmd = ($urandom_range(0, 1) != 0) ? REQ_UNDEF_6 : REQ_UNDEF_7;
            end
        end
        send_item(cmd, 8'($urandom), 6'($urandom), 1'($urandom), nib);
    endtask

    // Receiver: draw a hold per bus op, honor the long freeze, then take one
    initial begin : bus_sink
        int hold;
        int taken;
        taken = 0;
        forever begin
            hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0 || rx_freeze) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                while (rx_freeze) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid));
            taken++;
            if (taken % 25 == 0) rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Long hold-off on the bus side, counted here, while requests keep coming
    initial begin : hold_off
        wait (hold_off_go);
        @(negedge i_clk);
        rx_freeze = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        rx_freeze = 1'b0;
    end

    // Check every bus op at the edge where it is taken
    always @(posedge i_clk) begin
        t_bus_op got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.op     = o_bus_op;
            got.rs     = o_reg_select;
            got.nibble = o_nibble_out;
            got.units  = o_pause_units;
            got.last   = o_last;
            sb.check_op(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cmd           <= REQ_INIT;
        i_byte_value    <= 8'h00;
        i_cursor_column <= 6'd0;
        i_cursor_row    <= 1'b0;
        i_status_nibble <= 4'h0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dropped traffic: stray status answer while idle, undefined code
        send_item(REQ_STATUS, 8'h00, 6'd0, 1'b0, 4'hF);
        send_item(REQ_UNDEF_7, 8'hFF, 6'd63, 1'b1, 4'hF);

        // Init: first poll sees busy and repeats, a request mid-poll is dropped
        send_item(REQ_INIT, 8'h00, 6'd0, 1'b0, 4'h0);
        send_status(4'hF);
        send_status(4'h0);
        send_item(REQ_CLEAR, 8'hFF, 6'd63, 1'b1, 4'hF);
        send_status(4'h7);
        send_status(4'hF);
        repeat (3) begin
            send_status(4'h0);
            send_status(4'h0);
        end

        // One of each byte request, field extremes
        send_item(REQ_WRITE_CMD, 8'h00, 6'd0, 1'b0, 4'h0);
        send_status(4'h0);
        send_status(4'hF);
        send_item(REQ_WRITE_DATA, 8'hFF, 6'd0, 1'b0, 4'h0);
        send_status(4'h7);
        send_status(4'h0);
        send_item(REQ_SET_CURSOR, 8'h00, 6'd63, 1'b1, 4'h0);
        send_status(4'h0);
        send_status(4'h0);

        // Clear: command 0x01 then home address, each behind its own poll
        send_item(REQ_CLEAR, 8'h00, 6'd0, 1'b0, 4'h0);
        repeat (2) begin
            send_status(4'h0);
            send_status(4'h0);
        end

        while (sent_count < TOTAL_ITEMS) begin
            if (sent_count == HOLD_OFF_AT) hold_off_go = 1'b1;
            send_random();
        end
        i_valid <= 1'b0;

        // Drain: wait out every predicted bus op, then watch for extras
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: char_lcd_4bit_bus_sequencer.f
hw/rtl/lcd4seq_pkg.sv
hw/rtl/lcd4seq_front.sv
hw/rtl/lcd4seq_queue.sv
hw/rtl/lcd4seq_back.sv
hw/rtl/char_lcd_4bit_bus_sequencer.sv
test/tb_char_lcd_4bit_bus_sequencer.sv
